/* src/weo_pkg.sv */
// Shared types, widths and the arctangent table for the wheel odometry block.
`timescale 1ns / 1ps

package weo_pkg;

    // Field and register widths
    localparam int WHEEL_W   = 16;
    localparam int RADIUS_W  = 20;
    localparam int GAIN_W    = 31;
    localparam int POSE_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Shared multiplier: a: wheel sum, difference, distance; b: scale factors, cos, sin
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Rotator
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd21496;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 31'd245843627;

    // arctan(2^-i) in 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_RADIUS   = 3'd0,
        REG_TURN_GAIN      = 3'd1,
        REG_ORIGIN_X       = 3'd2,
        REG_ORIGIN_Y       = 3'd3,
        REG_ORIGIN_HEADING = 3'd4
    } cfg_reg_t;

    // Request opcodes
    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    // Heading quadrant
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_TURN,
        ST_ROT,
        ST_MULX,
        ST_MULY,
        ST_UPD,
        ST_FINISH
    } state_t;

    // Rotator control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } cordic_ctrl_t;

endpackage

/* src/weo_mul.sv */
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module weo_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [weo_pkg::MUL_A_W-1:0]    a,
    input  logic signed [weo_pkg::MUL_B_W-1:0]    b,
    output logic signed [weo_pkg::PROD_W-1:0]     prod
);
    import weo_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // One product per enabled cycle
    always_comb
    begin
        prod_next = PROD_W'(a) * PROD_W'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* src/weo_cordic.sv */
// Iterative CORDIC rotator: one micro-rotation per step, quadrant fold on the output.
`timescale 1ns / 1ps

module weo_cordic (
    input  logic                    clk,
    input  logic                    rst_n,
    input  weo_pkg::cordic_ctrl_t   ctrl,
    input  logic [31:0]             heading,
    output logic                    last,
    output logic signed [31:0]      cos_q30,
    output logic signed [31:0]      sin_q30
);
    import weo_pkg::*;

    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    quad_t              quad_reg, quad_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;

    logic [31:0]        h_bias;
    logic signed [31:0] xs, ys, ang;

    // Load: split heading into quadrant and residual; step: one rotation
    always_comb
    begin
        h_bias    = heading + 32'h2000_0000;
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        ang       = $signed(ATAN_TURNS[cnt_reg]);
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            quad_next = quad_t'(h_bias[31:30]);
            z_next    = $signed(heading - {h_bias[31:30], 30'b0});
            x_next    = CORDIC_GAIN_Q30;
            y_next    = 32'sd0;
            cnt_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            cnt_next = cnt_reg + STEP_W'(1);
        end
    end

    // Step counter is control; the datapath needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    assign last = (cnt_reg == LAST_STEP);

    // Rotate the first-quadrant result back by whole quarter turns
    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
            QUAD_90:
            begin
                cos_q30 = -y_reg;
                sin_q30 = x_reg;
            end
            QUAD_180:
            begin
                cos_q30 = -x_reg;
                sin_q30 = -y_reg;
            end
            QUAD_270:
            begin
                cos_q30 = y_reg;
                sin_q30 = -x_reg;
            end
            default:
            begin
                cos_q30 = x_reg;
                sin_q30 = y_reg;
            end
        endcase
    end

endmodule

/* src/wheel_encoder_odometry_top.sv */
// Top level of the differential-drive odometry block: sequencer, pose state and registers.
`timescale 1ns / 1ps

// Dead-reckoning pose tracker. A request with op = update adds the wheel
// travel to the pose; op = restart loads the pose from the origin registers.
// Every request returns one result, the pose after it. An update request
// runs through DIST, TURN, ROT, MULX, MULY, UPD and FINISH before in_ready
// is high again: the iterative CORDIC rotator steps in ROT, and the rest is
// four passes through the one shared multiplier, the pose update and the
// load of the output register. A restart request goes from IDLE to FINISH.
// The result goes to an output register, so a new request is taken while the
// previous result still waits; the sequencer only holds in its last state if
// that register is still full, which delays the return to idle.
// Configuration writes take effect at once and should happen while idle.
module wheel_encoder_odometry_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [weo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [weo_pkg::CFG_W-1:0]            cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic signed [weo_pkg::WHEEL_W-1:0]   left_wheel_delta,
    input  logic signed [weo_pkg::WHEEL_W-1:0]   right_wheel_delta,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [weo_pkg::POSE_W-1:0]    pose_x,
    output logic signed [weo_pkg::POSE_W-1:0]    pose_y,
    output logic [weo_pkg::POSE_W-1:0]           pose_heading
);
    import weo_pkg::*;

    // Configuration registers
    logic [RADIUS_W-1:0]      radius_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [POSE_W-1:0] origin_x_reg;
    logic signed [POSE_W-1:0] origin_y_reg;
    logic [POSE_W-1:0]        origin_heading_reg;

    // Pose state
    logic signed [POSE_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POSE_W-1:0] pos_y_reg, pos_y_next;
    logic [POSE_W-1:0]        heading_reg, heading_next;

    // Working registers
    state_t                    state_reg, state_next;
    logic signed [WHEEL_W-1:0] left_reg, right_reg;
    logic signed [MUL_A_W-1:0] dist_reg, dist_next;
    logic [POSE_W-1:0]         dh_reg, dh_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [POSE_W-1:0] out_x_reg, out_x_next;
    logic signed [POSE_W-1:0] out_y_reg, out_y_next;
    logic [POSE_W-1:0]        out_h_reg, out_h_next;

    // Shared units
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    cordic_ctrl_t              cordic_ctrl;
    logic                      cordic_last;
    logic signed [31:0]        cos_q30, sin_q30;

    logic                      in_fire;
    logic                      out_fire;
    logic signed [WHEEL_W:0]   wheel_sum, wheel_diff;
    logic signed [PROD_W-1:0]  prod_rnd9, prod_rnd12, prod_rnd34;
    logic signed [POSE_W:0]    sat_sum;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    weo_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    weo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cordic_ctrl),
        .heading (heading_reg),
        .last    (cordic_last),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg         <= RADIUS_RESET;
            gain_reg           <= GAIN_RESET;
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            origin_heading_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHEEL_RADIUS:   radius_reg         <= cfg_data[RADIUS_W-1:0];
                REG_TURN_GAIN:      gain_reg           <= cfg_data[GAIN_W-1:0];
                REG_ORIGIN_X:       origin_x_reg       <= $signed(cfg_data);
                REG_ORIGIN_Y:       origin_y_reg       <= $signed(cfg_data);
                REG_ORIGIN_HEADING: origin_heading_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Wheel sum and difference, roundings of the product register
    always_comb
    begin
        wheel_sum  = (WHEEL_W+1)'(left_reg) + (WHEEL_W+1)'(right_reg);
        wheel_diff = (WHEEL_W+1)'(right_reg) - (WHEEL_W+1)'(left_reg);
        prod_rnd9  = prod + PROD_W'(256);
        prod_rnd12 = prod + PROD_W'(2048);
        prod_rnd34 = prod + (PROD_W'(1) <<< 33);
    end

    // Sequencer: next state, multiplier operands, rotator control, pose and output updates
    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        dist_next      = dist_reg;
        dh_next        = dh_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_h_next     = out_h_reg;
        mul_en         = 1'b0;
        mul_a          = MUL_A_W'(wheel_sum);
        mul_b          = MUL_B_W'(radius_reg);
        cordic_ctrl    = '0;
        in_ready       = (state_reg == ST_IDLE);
        sat_sum        = (POSE_W+1)'(pos_x_reg) + (POSE_W+1)'($signed(prod_rnd34[PROD_W-1:34]));

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_RESTART)
                    begin
                        pos_x_next   = origin_x_reg;
                        pos_y_next   = origin_y_reg;
                        heading_next = origin_heading_reg;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST:
            begin
                // (L + R) * radius; start the rotator on the old heading
                mul_en           = 1'b1;
                cordic_ctrl.load = 1'b1;
                state_next       = ST_TURN;
            end
            ST_TURN:
            begin
                // (R - L) * turn gain; distance rounded to 2^-24 m
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(wheel_diff);
                mul_b      = MUL_B_W'(gain_reg);
                dist_next  = prod_rnd9[MUL_A_W+8:9];
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cordic_ctrl.step = 1'b1;
                dh_next          = prod_rnd12[POSE_W+11:12];
                if (cordic_last)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                mul_en     = 1'b1;
                mul_a      = dist_reg;
                mul_b      = cos_q30;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                mul_en = 1'b1;
                mul_a  = dist_reg;
                mul_b  = sin_q30;
                // saturating x update from d * cos
                if (sat_sum[POSE_W] != sat_sum[POSE_W-1])
                begin
                    pos_x_next = sat_sum[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}}
                                                 : {1'b0, {(POSE_W-1){1'b1}}};
                end
                else
                begin
                    pos_x_next = sat_sum[POSE_W-1:0];
                end
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // saturating y update from d * sin, heading wraps
                sat_sum = (POSE_W+1)'(pos_y_reg)
                        + (POSE_W+1)'($signed(prod_rnd34[PROD_W-1:34]));
                if (sat_sum[POSE_W] != sat_sum[POSE_W-1])
                begin
                    pos_y_next = sat_sum[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}}
                                                 : {1'b0, {(POSE_W-1){1'b1}}};
                end
                else
                begin
                    pos_y_next = sat_sum[POSE_W-1:0];
                end
                heading_next = heading_reg + dh_reg;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = pos_x_reg;
                    out_y_next     = pos_y_reg;
                    out_h_next     = heading_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_reg  <= left_wheel_delta;
            right_reg <= right_wheel_delta;
        end
        dist_reg  <= dist_next;
        dh_reg    <= dh_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
    end

    assign out_valid    = out_valid_reg;
    assign pose_x       = out_x_reg;
    assign pose_y       = out_y_reg;
    assign pose_heading = out_h_reg;

    // A restart request loads the origin heading into the pose
    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op == OP_RESTART) |=> heading_reg == $past(origin_heading_reg))
        else $error("restart did not load origin heading");

    // Heading moves only on a restart or in the update state
    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire && (state_reg != ST_UPD) |=> $stable(heading_reg))
        else $error("heading changed outside an update");

    // The rotator has run all its steps before the x product is formed
    a_rot_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MULX |-> $past(state_reg) == ST_ROT && $past(cordic_last))
        else $error("x product started before rotation finished");

endmodule
